/* rtl/core/tcgr_pkg.sv */
`timescale 1ns / 1ps
package tcgr_pkg;
  localparam int DISPLAY_WIDTH = 128;
  localparam int MAX_PAGES = 8;
  localparam int GLYPH_COLS = 6;
  localparam int CELL_PX = 8;
  localparam int ROW_LIMIT = 64;
  // frame RAM address width, wide enough for DISPLAY_WIDTH * MAX_PAGES bytes
  localparam int MEM_AW = 11;
  localparam logic [7:0] FIRST_CODE = 8'h20;
  localparam logic [7:0] LAST_CODE = 8'h7F;
  localparam logic [7:0] SUBST_CODE = 8'h3F;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [3:0] PAGE_COUNT_RESET = 4'd4;

  localparam logic [1:0] REQ_PRINT = 2'd0;
  localparam logic [1:0] REQ_CURSOR = 2'd1;
  localparam logic [1:0] REQ_PIXEL = 2'd2;
  localparam logic [1:0] REQ_READ = 2'd3;

  localparam logic [1:0] COLOR_SET = 2'b01;
  localparam logic [1:0] COLOR_CLEAR = 2'b00;
  localparam logic [1:0] COLOR_INVERT = 2'b11;

  localparam logic [7:0] FONT_ROM [576] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h2f,8'h00,8'h00,
    8'h00,8'h00,8'h07,8'h00,8'h07,8'h00, 8'h00,8'h14,8'h7f,8'h14,8'h7f,8'h14,
    8'h00,8'h24,8'h2a,8'h7f,8'h2a,8'h12, 8'h00,8'h23,8'h13,8'h08,8'h64,8'h62,
    8'h00,8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h00,8'h05,8'h03,8'h00,8'h00,
    8'h00,8'h00,8'h1c,8'h22,8'h41,8'h00, 8'h00,8'h00,8'h41,8'h22,8'h1c,8'h00,
    8'h00,8'h14,8'h08,8'h3E,8'h08,8'h14, 8'h00,8'h08,8'h08,8'h3E,8'h08,8'h08,
    8'h00,8'h00,8'h00,8'hA0,8'h60,8'h00, 8'h00,8'h08,8'h08,8'h08,8'h08,8'h08,
    8'h00,8'h00,8'h60,8'h60,8'h00,8'h00, 8'h00,8'h20,8'h10,8'h08,8'h04,8'h02,
    8'h00,8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h00,8'h42,8'h7F,8'h40,8'h00,
    8'h00,8'h42,8'h61,8'h51,8'h49,8'h46, 8'h00,8'h21,8'h41,8'h45,8'h4B,8'h31,
    8'h00,8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h00,8'h27,8'h45,8'h45,8'h45,8'h39,
    8'h00,8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h00,8'h01,8'h71,8'h09,8'h05,8'h03,
    8'h00,8'h36,8'h49,8'h49,8'h49,8'h36, 8'h00,8'h06,8'h49,8'h49,8'h29,8'h1E,
    8'h00,8'h00,8'h36,8'h36,8'h00,8'h00, 8'h00,8'h00,8'h56,8'h36,8'h00,8'h00,
    8'h00,8'h08,8'h14,8'h22,8'h41,8'h00, 8'h00,8'h14,8'h14,8'h14,8'h14,8'h14,
    8'h00,8'h00,8'h41,8'h22,8'h14,8'h08, 8'h00,8'h02,8'h01,8'h51,8'h09,8'h06,
    8'h00,8'h32,8'h49,8'h59,8'h51,8'h3E, 8'h00,8'h7C,8'h12,8'h11,8'h12,8'h7C,
    8'h00,8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h00,8'h3E,8'h41,8'h41,8'h41,8'h22,
    8'h00,8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h00,8'h7F,8'h49,8'h49,8'h49,8'h41,
    8'h00,8'h7F,8'h09,8'h09,8'h09,8'h01, 8'h00,8'h3E,8'h41,8'h49,8'h49,8'h7A,
    8'h00,8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h00,8'h41,8'h7F,8'h41,8'h00,
    8'h00,8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h00,8'h7F,8'h08,8'h14,8'h22,8'h41,
    8'h00,8'h7F,8'h40,8'h40,8'h40,8'h40, 8'h00,8'h7F,8'h02,8'h0C,8'h02,8'h7F,
    8'h00,8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h00,8'h3E,8'h41,8'h41,8'h41,8'h3E,
    8'h00,8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h00,8'h3E,8'h41,8'h51,8'h21,8'h5E,
    8'h00,8'h7F,8'h09,8'h19,8'h29,8'h46, 8'h00,8'h46,8'h49,8'h49,8'h49,8'h31,
    8'h00,8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h00,8'h3F,8'h40,8'h40,8'h40,8'h3F,
    8'h00,8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h00,8'h3F,8'h40,8'h38,8'h40,8'h3F,
    8'h00,8'h63,8'h14,8'h08,8'h14,8'h63, 8'h00,8'h07,8'h08,8'h70,8'h08,8'h07,
    8'h00,8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h00,8'h7F,8'h41,8'h41,8'h00,
    8'h00,8'h55,8'h2A,8'h55,8'h2A,8'h55, 8'h00,8'h00,8'h41,8'h41,8'h7F,8'h00,
    8'h00,8'h04,8'h02,8'h01,8'h02,8'h04, 8'h00,8'h40,8'h40,8'h40,8'h40,8'h40,
    8'h00,8'h00,8'h01,8'h02,8'h04,8'h00, 8'h00,8'h20,8'h54,8'h54,8'h54,8'h78,
    8'h00,8'h7F,8'h48,8'h44,8'h44,8'h38, 8'h00,8'h38,8'h44,8'h44,8'h44,8'h20,
    8'h00,8'h38,8'h44,8'h44,8'h48,8'h7F, 8'h00,8'h38,8'h54,8'h54,8'h54,8'h18,
    8'h00,8'h08,8'h7E,8'h09,8'h01,8'h02, 8'h00,8'h18,8'hA4,8'hA4,8'hA4,8'h7C,
    8'h00,8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h00,8'h44,8'h7D,8'h40,8'h00,
    8'h00,8'h40,8'h80,8'h84,8'h7D,8'h00, 8'h00,8'h7F,8'h10,8'h28,8'h44,8'h00,
    8'h00,8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h00,8'h7C,8'h04,8'h18,8'h04,8'h78,
    8'h00,8'h7C,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h38,8'h44,8'h44,8'h44,8'h38,
    8'h00,8'hFC,8'h24,8'h24,8'h24,8'h18, 8'h00,8'h18,8'h24,8'h24,8'h18,8'hFC,
    8'h00,8'h7C,8'h08,8'h04,8'h04,8'h08, 8'h00,8'h48,8'h54,8'h54,8'h54,8'h20,
    8'h00,8'h04,8'h3F,8'h44,8'h40,8'h20, 8'h00,8'h3C,8'h40,8'h40,8'h20,8'h7C,
    8'h00,8'h1C,8'h20,8'h40,8'h20,8'h1C, 8'h00,8'h3C,8'h40,8'h30,8'h40,8'h3C,
    8'h00,8'h44,8'h28,8'h10,8'h28,8'h44, 8'h00,8'h1C,8'hA0,8'hA0,8'hA0,8'h7C,
    8'h00,8'h44,8'h64,8'h54,8'h4C,8'h44, 8'h00,8'h00,8'h08,8'h77,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h7F,8'h00,8'h00, 8'h00,8'h00,8'h77,8'h08,8'h00,8'h00,
    8'h00,8'h10,8'h08,8'h10,8'h08,8'h00, 8'h14,8'h14,8'h14,8'h14,8'h14,8'h14
  };

  // one frame store access issued by the sequencer
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [MEM_AW-1:0] raddr;
    logic [MEM_AW-1:0] waddr;
    logic [7:0]        wdata;
  } mem_req_t;
endpackage

/* rtl/core/tcgr_frame_ram.sv */
`timescale 1ns / 1ps
module tcgr_frame_ram #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  logic                 clk,
  input  tcgr_pkg::mem_req_t   req,
  output logic [7:0]           rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.raddr[AW-1:0]];
    end
  end
endmodule

/* rtl/core/text_console_glyph_renderer_unit.sv */
`timescale 1ns / 1ps
// Reads: the output beat is offered in S_RDOUT, after the RAM read in S_RDW.
// Per input beat: print writes 8 glyph bytes, one per cycle, then idles; pixel
// does a read-modify-write, read waits out any output stall, cursor/newline only move the cursor.
// A scroll copies (pages-1)*W bytes up a page and clears W bytes ahead of the glyph.
// Throughput: one beat at a time; input stalls until the sequencer idles.
// Reset: synchronous; RAM clear sweep over W*MAX_PAGES bytes, cursor 0, page_count 4.
module text_console_glyph_renderer_unit #(
  parameter int DISPLAY_WIDTH = tcgr_pkg::DISPLAY_WIDTH,
  parameter int MAX_PAGES = tcgr_pkg::MAX_PAGES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [7:0]        char_code,
  input  logic [3:0]        cursor_col,
  input  logic [2:0]        cursor_row,
  input  logic [7:0]        pixel_x,
  input  logic [6:0]        pixel_y,
  input  logic signed [1:0] color_mode,
  input  logic [9:0]        read_addr,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        read_data
);
  localparam int XW = $clog2(DISPLAY_WIDTH + 1);
  localparam int DEPTH = DISPLAY_WIDTH * MAX_PAGES;
  localparam int AW = $clog2(DEPTH);
  localparam int MW = tcgr_pkg::MEM_AW;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCRD  = 4'd2;   // scroll: read source byte
  localparam logic [3:0] S_SCWR  = 4'd3;   // scroll: write it a page up
  localparam logic [3:0] S_SCCL  = 4'd4;   // scroll: clear bottom page
  localparam logic [3:0] S_GLYPH = 4'd5;
  localparam logic [3:0] S_PXRD  = 4'd6;
  localparam logic [3:0] S_PXWR  = 4'd7;
  localparam logic [3:0] S_RDW   = 4'd8;
  localparam logic [3:0] S_RDOUT = 4'd9;

  logic [3:0]    state;
  logic [3:0]    page_count;
  logic [XW-1:0] cx;          // cursor x, 0..W
  logic [6:0]    cy;          // cursor y, 0..64
  logic [AW:0]   cnt;         // shared address/sweep counter
  logic [7:0]    code;
  logic [2:0]    pbit;
  logic [1:0]    pmode;
  logic [AW-1:0] paddr;
  logic          rd_oob;
  logic [7:0]    rdata;
  tcgr_pkg::mem_req_t mreq;

  // effective pages 1..MAX_PAGES
  logic [3:0] npages;
  always_comb begin
    if (page_count == 4'd0) npages = 4'd1;
    else if (32'(page_count) > MAX_PAGES) npages = 4'(MAX_PAGES);
    else npages = page_count;
  end
  logic [6:0] height;
  assign height = {npages[3:0], 3'b000} > 7'd64 ? 7'd64 : 7'({npages, 3'b000});

  function automatic logic [6:0] next_row(input logic [6:0] y);
    logic [7:0] n;
    n = {1'b0, y} + 8'd8;
    return n > 8'd64 ? 7'd64 : n[6:0];
  endfunction

  tcgr_frame_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk(clk), .req(mreq), .rdata(rdata)
  );

  // print setup: wrap, then scroll check
  logic [6:0] wrap_y;
  assign wrap_y = 32'(cx) >= DISPLAY_WIDTH ? next_row(cy) : cy;
  logic [7:0] pcode;
  assign pcode = (char_code < tcgr_pkg::FIRST_CODE || char_code > tcgr_pkg::LAST_CODE)
                 ? tcgr_pkg::SUBST_CODE : char_code;

  // glyph byte for cnt 0..7
  logic [2:0]  gcol;
  logic [9:0]  rom_idx;
  logic [7:0]  gbyte;
  logic [XW:0] gx;
  assign gcol = cnt[2:0];
  assign rom_idx = 10'(({2'b00, code} - {2'b00, tcgr_pkg::FIRST_CODE}) * 10'd6) + 10'(gcol);
  assign gbyte = (gcol < 3'd6) ? tcgr_pkg::FONT_ROM[rom_idx] : 8'h00;
  assign gx = {1'b0, cx} + (XW+1)'(gcol);

  logic [AW:0] last_base;  // (n-1)*W
  assign last_base = (AW+1)'((32'(npages) - 1) * DISPLAY_WIDTH);
  logic [AW:0] cy_base;
  assign cy_base = (AW+1)'(32'(cy[6:3]) * DISPLAY_WIDTH);

  logic [7:0] bitmask;
  assign bitmask = 8'd1 << pbit;

  always_comb begin
    mreq = '0;
    unique case (state)
      S_CLR: begin
        mreq.wr = 1'b1;
        mreq.waddr = MW'(cnt);
      end
      S_SCRD: begin
        mreq.rd = 1'b1;
        mreq.raddr = MW'(cnt + (AW+1)'(DISPLAY_WIDTH));
      end
      S_SCWR: begin
        mreq.wr = 1'b1;
        mreq.waddr = MW'(cnt);
        mreq.wdata = rdata;
      end
      S_SCCL: begin
        mreq.wr = 1'b1;
        mreq.waddr = MW'(cnt);
      end
      S_GLYPH: begin
        mreq.wr = (32'(gx) < DISPLAY_WIDTH) && (cy[6:3] < 4'(MAX_PAGES));
        mreq.waddr = MW'(cy_base + (AW+1)'(gx));
        mreq.wdata = gbyte;
      end
      S_PXRD: begin
        mreq.rd = 1'b1;
        mreq.raddr = MW'(paddr);
      end
      S_PXWR: begin
        mreq.wr = 1'b1;
        mreq.waddr = MW'(paddr);
        case (pmode)
          tcgr_pkg::COLOR_SET:    mreq.wdata = rdata | bitmask;
          tcgr_pkg::COLOR_CLEAR:  mreq.wdata = rdata & ~bitmask;
          tcgr_pkg::COLOR_INVERT: mreq.wdata = rdata ^ bitmask;
          default:                mreq.wdata = rdata;
        endcase
      end
      S_RDW: begin
        mreq.rd = 1'b1;
        mreq.raddr = MW'(paddr);
      end
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_RDOUT);
  // RAM output holds while the beat waits: no other read is issued in S_RDOUT
  assign read_data = rd_oob ? 8'h00 : rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cnt <= '0;
      page_count <= tcgr_pkg::PAGE_COUNT_RESET;
      cx <= '0;
      cy <= '0;
    end else begin
      if (cfg_we) page_count <= cfg_wdata;
      unique case (state)
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (32'(cnt) == DEPTH - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            unique case (req_type)
              tcgr_pkg::REQ_PRINT: begin
                code <= pcode;
                if (char_code == tcgr_pkg::NEWLINE_CODE) begin
                  cx <= '0;
                  cy <= next_row(cy);
                end else if (wrap_y >= height) begin
                  // scroll first; cursor lands on column 0 of the last page
                  cx <= '0;
                  cy <= height - 7'd8;
                  cnt <= '0;
                  state <= (npages == 4'd1) ? S_SCCL : S_SCRD;
                end else begin
                  if (32'(cx) >= DISPLAY_WIDTH) cx <= '0;
                  cy <= wrap_y;
                  cnt <= '0;
                  state <= S_GLYPH;
                end
              end
              tcgr_pkg::REQ_CURSOR: begin
                cx <= XW'({cursor_col, 3'b000});
                cy <= {1'b0, cursor_row, 3'b000};
              end
              tcgr_pkg::REQ_PIXEL: begin
                paddr <= AW'(32'(pixel_y[6:3]) * DISPLAY_WIDTH + 32'(pixel_x));
                pbit <= pixel_y[2:0];
                pmode <= color_mode;
                if (32'(pixel_x) < DISPLAY_WIDTH && pixel_y < height) state <= S_PXRD;
              end
              tcgr_pkg::REQ_READ: begin
                rd_oob <= 32'(read_addr) >= DEPTH;
                paddr <= AW'(read_addr);
                state <= S_RDW;
              end
              default: ;
            endcase
          end
        end
        S_SCRD: state <= S_SCWR;
        S_SCWR: begin
          if (cnt + 1'b1 == last_base) state <= S_SCCL;
          else state <= S_SCRD;
          cnt <= cnt + 1'b1;
        end
        S_SCCL: begin
          if (cnt == last_base + (AW+1)'(DISPLAY_WIDTH - 1)) begin
            cnt <= '0;
            state <= S_GLYPH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_GLYPH: begin
          cnt <= cnt + 1'b1;
          if (cnt[2:0] == 3'd7) begin
            state <= S_IDLE;
            if (32'(cx) + 8 > DISPLAY_WIDTH) cx <= XW'(DISPLAY_WIDTH);
            else cx <= cx + XW'(8);
          end
        end
        S_PXRD: state <= S_PXWR;
        S_PXWR: state <= S_IDLE;
        S_RDW: state <= S_RDOUT;
        S_RDOUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  localparam int W = tcgr_pkg::DISPLAY_WIDTH;
  localparam int NP = tcgr_pkg::MAX_PAGES;
  localparam int CPX = tcgr_pkg::CELL_PX;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT hookup
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = '0;
  logic [7:0] char_code = '0;
  logic [3:0] cursor_col = '0;
  logic [2:0] cursor_row = '0;
  logic [7:0] pixel_x = '0;
  logic [6:0] pixel_y = '0;
  logic signed [1:0] color_mode = '0;
  logic [9:0] read_addr = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] read_data;

  always #5 clk = ~clk;

  text_console_glyph_renderer_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .char_code(char_code), .cursor_col(cursor_col), .cursor_row(cursor_row),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .color_mode(color_mode),
    .read_addr(read_addr), .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow console: frame store, cursor and page count mirrored in the bench
  // ---------------------------------------------------------------------------
  logic [7:0] shadow_frame [NP*W];
  int unsigned shadow_cx, shadow_cy;
  logic [3:0] shadow_pages_reg;
  logic [7:0] pending_bytes [$];   // read bytes still owed by the DUT
  int errors = 0;
  int cycles = 0;
  localparam int CYCLE_LIMIT = 2000000;

  function automatic int unsigned used_pages();
    if (shadow_pages_reg == 0) return 1;
    if (shadow_pages_reg > NP) return NP;
    return shadow_pages_reg;
  endfunction

  function automatic int unsigned advance_row(int unsigned y);
    return (y + CPX > tcgr_pkg::ROW_LIMIT) ? tcgr_pkg::ROW_LIMIT : y + CPX;
  endfunction

  task automatic shadow_print(logic [7:0] code_in);
    int unsigned n, pg, base, cx;
    logic [7:0] code;
    n = used_pages();
    code = code_in;
    if (code == tcgr_pkg::NEWLINE_CODE) begin
      shadow_cx = 0;
      shadow_cy = advance_row(shadow_cy);
      return;
    end
    if (code < tcgr_pkg::FIRST_CODE || code > tcgr_pkg::LAST_CODE) begin
      code = tcgr_pkg::SUBST_CODE;
    end
    if (shadow_cx >= W) begin
      shadow_cx = 0;
      shadow_cy = advance_row(shadow_cy);
    end
    // scroll: used pages shift up one, bottom used page cleared
    if (shadow_cy >= n * CPX) begin
      for (int i = 0; i < (n - 1) * W; i++)
        shadow_frame[i] = shadow_frame[i + W];
      for (int i = 0; i < W; i++)
        shadow_frame[(n - 1) * W + i] = 8'h00;
      shadow_cx = 0;
      shadow_cy = (n - 1) * CPX;
    end
    pg = shadow_cy / CPX;
    base = (code - tcgr_pkg::FIRST_CODE) * tcgr_pkg::GLYPH_COLS;
    if (pg < NP) begin
      for (int c = 0; c < CPX; c++) begin
        cx = shadow_cx + c;
        if (cx >= W) break;
        shadow_frame[pg * W + cx] =
          (c < tcgr_pkg::GLYPH_COLS) ? tcgr_pkg::FONT_ROM[base + c] : 8'h00;
      end
    end
    shadow_cx = shadow_cx + CPX;
    if (shadow_cx > W) shadow_cx = W;
  endtask

  task automatic shadow_apply(logic [1:0] rq, logic [7:0] ch, logic [3:0] ccol,
                              logic [2:0] crow, logic [7:0] px, logic [6:0] py,
                              logic [1:0] cm, logic [9:0] ra);
    int unsigned idx;
    case (rq)
      tcgr_pkg::REQ_PRINT: shadow_print(ch);
      tcgr_pkg::REQ_CURSOR: begin
        shadow_cx = ccol * CPX;
        shadow_cy = crow * CPX;
      end
      tcgr_pkg::REQ_PIXEL: begin
        if (px < W && py < used_pages() * CPX) begin
          idx = (py >> 3) * W + px;
          if (cm == tcgr_pkg::COLOR_SET) shadow_frame[idx][py[2:0]] = 1'b1;
          else if (cm == tcgr_pkg::COLOR_CLEAR) shadow_frame[idx][py[2:0]] = 1'b0;
          else if (cm == tcgr_pkg::COLOR_INVERT) shadow_frame[idx][py[2:0]] ^= 1'b1;
        end
      end
      default: pending_bytes.push_back(ra < NP*W ? shadow_frame[ra] : 8'h00);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall drawn per beat, compare every accepted beat
  // ---------------------------------------------------------------------------
  int out_hold = 0;
  int hold_draw;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected read beat, expected none actual %02h",
                   $time, read_data);
          errors++;
        end else begin
          if (read_data !== pending_bytes[0]) begin
            $display("%0t: read_data mismatch expected %02h actual %02h",
                     $time, pending_bytes[0], read_data);
            errors++;
          end
          void'(pending_bytes.pop_front());
        end
      end
      // after each accepted beat, hold off the next one for a randomly drawn time
      if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_stall <= (out_hold > 1);
      end else if (out_valid && !out_stall) begin
        hold_draw = $urandom_range(0, 12);
        out_hold <= hold_draw;
        out_stall <= (hold_draw != 0);
      end else out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  bit idle_gaps = 1'b1;

  // Send one beat; the shadow is updated once the DUT no longer stalls.
  task automatic send_beat(logic [1:0] rq, logic [7:0] ch, logic [3:0] ccol,
                           logic [2:0] crow, logic [7:0] px, logic [6:0] py,
                           logic [1:0] cm, logic [9:0] ra);
    int gap;
    gap = idle_gaps ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq; char_code <= ch; cursor_col <= ccol; cursor_row <= crow;
    pixel_x <= px; pixel_y <= py; color_mode <= cm; read_addr <= ra;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow_apply(rq, ch, ccol, crow, px, py, cm, ra);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic put_char(logic [7:0] ch);
    send_beat(tcgr_pkg::REQ_PRINT, ch, 4'($urandom), 3'($urandom), 8'($urandom),
              7'($urandom), 2'($urandom), 10'($urandom));
  endtask

  task automatic put_cursor(logic [3:0] c, logic [2:0] r);
    send_beat(tcgr_pkg::REQ_CURSOR, 8'($urandom), c, r, 8'($urandom),
              7'($urandom), 2'($urandom), 10'($urandom));
  endtask

  task automatic put_pixel(logic [7:0] x, logic [6:0] y, logic [1:0] m);
    send_beat(tcgr_pkg::REQ_PIXEL, 8'($urandom), 4'($urandom), 3'($urandom),
              x, y, m, 10'($urandom));
  endtask

  task automatic get_byte(logic [9:0] a);
    send_beat(tcgr_pkg::REQ_READ, 8'($urandom), 4'($urandom), 3'($urandom),
              8'($urandom), 7'($urandom), 2'($urandom), a);
  endtask

  // Drain all reads and let scroll/print work finish.
  task automatic wait_drained();
    drop_valid();
    while (pending_bytes.size() != 0 || in_stall) @(posedge clk);
  endtask

  task automatic set_pages(logic [3:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_pages_reg = v;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    put_char(8'h41);              // plain glyph
    put_char(8'h7F);              // DEL has its own glyph
    put_char(8'h00);              // control code -> '?'
    put_char(8'hFF);              // high code -> '?'
    put_char(8'h20);
    put_char(tcgr_pkg::NEWLINE_CODE);
    for (int i = 0; i < 8; i++) get_byte(10'(i));
    get_byte(10'd8);
    put_cursor(4'd15, 3'd7);      // past display height: next print scrolls
    put_char(8'h7E);
    get_byte(10'd384);
    put_pixel(8'd0, 7'd0, tcgr_pkg::COLOR_SET);
    put_pixel(8'd127, 7'd31, tcgr_pkg::COLOR_SET);
    put_pixel(8'd127, 7'd31, tcgr_pkg::COLOR_INVERT);
    put_pixel(8'd0, 7'd0, tcgr_pkg::COLOR_CLEAR);
    put_pixel(8'd200, 7'd3, tcgr_pkg::COLOR_SET);   // x clipped
    put_pixel(8'd5, 7'd127, tcgr_pkg::COLOR_SET);   // y clipped
    put_pixel(8'd5, 7'd2, 2'b10);                   // unused mode
    get_byte(10'd0);
    get_byte(10'd511);
    get_byte(10'd1023);
  endtask

  // Fill a row to force right-edge wrap, then keep going to force scrolls.
  task automatic test_wrap_scroll();
    put_cursor(4'd14, 3'd2);
    for (int i = 0; i < 40; i++) put_char(8'($urandom_range(32, 126)));
    for (int i = 0; i < 6; i++) put_char(tcgr_pkg::NEWLINE_CODE);
    put_char(8'h5A);
    for (int i = 0; i < 6; i++) get_byte(10'($urandom_range(0, 1023)));
  endtask

  task automatic test_random(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        if ($urandom_range(0, 9) == 0) put_char(8'($urandom));
        else if ($urandom_range(0, 15) == 0) put_char(tcgr_pkg::NEWLINE_CODE);
        else put_char(8'($urandom_range(32, 127)));
      end else if (k < 52) put_cursor(4'($urandom), 3'($urandom));
      else if (k < 70) begin
        if ($urandom_range(0, 3) == 0) begin
          put_pixel(8'($urandom), 7'($urandom), 2'($urandom));
        end else begin
          put_pixel(8'($urandom_range(0, 127)), 7'($urandom_range(0, 63)),
                    2'($urandom));
        end
      end else begin
        if ($urandom_range(0, 3) == 0) get_byte(10'($urandom));
        else get_byte(10'($urandom_range(0, used_pages() * W - 1)));
      end
    end
  endtask

  task automatic test_back_to_back();
    idle_gaps = 1'b0;
    test_random(40);
    idle_gaps = 1'b1;
  endtask

  // Sample every 16th byte of the used region so stale bytes are caught.
  task automatic test_dump();
    for (int a = 0; a < used_pages() * W; a += 16) get_byte(10'(a));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < NP*W; i++) shadow_frame[i] = 8'h00;
    shadow_cx = 0;
    shadow_cy = 0;
    shadow_pages_reg = tcgr_pkg::PAGE_COUNT_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_wrap_scroll();
    test_random(30);
    wait_drained();               // sender holds until every read is back
    test_back_to_back();
    set_pages(4'd1);
    test_wrap_scroll();
    test_random(20);
    set_pages(4'd8);
    test_wrap_scroll();
    test_random(30);
    set_pages(4'd0);              // acts as one page
    test_random(15);
    set_pages(4'd15);             // acts as eight pages
    test_random(20);
    test_dump();
    set_pages(4'd3);
    test_random(20);

    drop_valid();
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/core/tcgr_pkg.sv
rtl/core/tcgr_frame_ram.sv
rtl/core/text_console_glyph_renderer_unit.sv
tb/testbench.sv
